@@ rtl/tbpf_pkg.sv @@
// tbpf_pkg: shared types and constants for the background tile pixel fetcher
// used by the top level and the testbench; no dependencies
package tbpf_pkg;

  // video memory geometry, byte offsets from 0x8000
  localparam int VRAM_AW = 13;
  localparam int MAP_AW  = 11;  // tile map region 0x9800..0x9fff
  localparam int BANK_AW = 12;  // even / odd byte banks

  localparam logic [1:0] MAP_REGION = 2'b11;  // vram_addr[12:11] of the map area

  // lcd_control bits
  localparam int LCDC_MAP_SEL  = 3;
  localparam int LCDC_DATA_SEL = 4;

  // request kinds
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_RENDER = 1'b1;

  // configuration register indexes
  localparam logic [7:0] CFG_LCD_CONTROL = 8'd0;
  localparam logic [7:0] CFG_SCROLL_Y    = 8'd1;
  localparam logic [7:0] CFG_SCROLL_X    = 8'd2;
  localparam logic [7:0] CFG_BG_PALETTE  = 8'd3;

  typedef struct packed {
    logic               req_type;
    logic [VRAM_AW-1:0] vram_addr;
    logic [7:0]         write_data;
    logic [7:0]         pixel_col;
    logic [7:0]         screen_line;
  } req_t;

  typedef struct packed {
    logic [7:0] out_col;
    logic [1:0] color_index;
    logic [1:0] pixel_shade;
  } res_t;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] value;
  } cfg_t;

endpackage

@@ rtl/tbpf_stream_if.sv @@
// tbpf_stream_if: valid/ready channel carrying one word of a chosen payload type
// payload types come from tbpf_pkg
interface tbpf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tbpf_ram.sv @@
// tbpf_ram: generic single write port, single read port ram with registered read
// no dependencies
module tbpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/tile_background_pixel_fetch_top.sv @@
// tile_background_pixel_fetch_top: a render word passes the stage 1, 2 and 3 registers
// then the output register; one word is accepted per cycle while no skid word is held.
// the rate is set by the three memories (map copy, even and odd tile-data banks),
// each read and written once per stage. reset clears config registers and valid bits
// only; video memory has no clearing pass and is undefined until written.
// uses tbpf_pkg, tbpf_stream_if and tbpf_ram
module tile_background_pixel_fetch_top #(
  parameter int SCREEN_COLS = 160
) (
  input  logic           clk,
  input  logic           rst,
  tbpf_stream_if.sink    cfg,
  tbpf_stream_if.sink    req,
  tbpf_stream_if.source  res
);

  localparam logic [8:0] COL_LIMIT = 9'(SCREEN_COLS);

  // configuration registers
  logic [7:0] lcd_control;
  logic [7:0] scroll_y;
  logic [7:0] scroll_x;
  logic [7:0] bg_palette;

  // config port never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control <= '0;
      scroll_y    <= '0;
      scroll_x    <= '0;
      bg_palette  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        tbpf_pkg::CFG_LCD_CONTROL: lcd_control <= cfg.data.value;
        tbpf_pkg::CFG_SCROLL_Y:    scroll_y    <= cfg.data.value;
        tbpf_pkg::CFG_SCROLL_X:    scroll_x    <= cfg.data.value;
        tbpf_pkg::CFG_BG_PALETTE:  bg_palette  <= cfg.data.value;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // whole pipeline moves together; it holds only while the skid stage is full
  logic adv;
  logic skid_valid;
  assign adv       = !skid_valid;
  assign req.ready = adv;

  logic accept;
  assign accept = req.valid && adv;

  // ---------------------------------------------------------------------------
  // stage 0: scroll the pixel position and address the tile map
  // ---------------------------------------------------------------------------
  logic [7:0] y_pos;
  logic [7:0] x_pos;
  logic       is_write;
  logic       on_screen;
  logic [tbpf_pkg::MAP_AW-1:0] map_raddr;
  logic map_we;

  assign y_pos     = scroll_y + req.data.screen_line;
  assign x_pos     = scroll_x + req.data.pixel_col;
  assign is_write  = (req.data.req_type == tbpf_pkg::REQ_WRITE);
  assign on_screen = ({1'b0, req.data.pixel_col} < COL_LIMIT);
  // map row of 32 tiles, so the column wraps inside the row
  assign map_raddr = {lcd_control[tbpf_pkg::LCDC_MAP_SEL], y_pos[7:3], x_pos[7:3]};

  // the map copy only tracks writes that land in the map area; it is written
  // in the same stage where it is read, so program order holds
  assign map_we = accept && is_write &&
                  (req.data.vram_addr[tbpf_pkg::VRAM_AW-1 -: 2] == tbpf_pkg::MAP_REGION);

  logic [7:0] p1_tile;

  tbpf_ram #(
    .WIDTH (8),
    .DEPTH (1 << tbpf_pkg::MAP_AW)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (req.data.vram_addr[tbpf_pkg::MAP_AW-1:0]),
    .wdata (req.data.write_data),
    .re    (adv),
    .raddr (map_raddr),
    .rdata (p1_tile)
  );

  // stage 1 registers; off-screen renders enter as bubbles
  logic                         p1_valid;
  logic                         p1_write;
  logic [tbpf_pkg::VRAM_AW-1:0] p1_waddr;
  logic [7:0]                   p1_wdata;
  logic [7:0]                   p1_col;
  logic [2:0]                   p1_fine_y;
  logic [2:0]                   p1_fine_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= accept && (is_write || on_screen);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_write  <= is_write;
      p1_waddr  <= req.data.vram_addr;
      p1_wdata  <= req.data.write_data;
      p1_col    <= req.data.pixel_col;
      p1_fine_y <= y_pos[2:0];
      p1_fine_x <= x_pos[2:0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: tile row address
  // signed mode: 0x9000 + tile*16 - (tile[7] ? 0x1000 : 0) folds to a top bit of
  // ~tile[7]; unsigned mode from 0x8000 has a top bit of zero
  // ---------------------------------------------------------------------------
  logic                         data_hi;
  logic [tbpf_pkg::BANK_AW-1:0] row_addr;

  assign data_hi  = !lcd_control[tbpf_pkg::LCDC_DATA_SEL] && !p1_tile[7];
  assign row_addr = {data_hi, p1_tile, p1_fine_y};  // byte pair index, low plane even

  logic                         p2_valid;
  logic                         p2_write;
  logic [tbpf_pkg::VRAM_AW-1:0] p2_waddr;
  logic [7:0]                   p2_wdata;
  logic [7:0]                   p2_col;
  logic [2:0]                   p2_fine_x;
  logic [tbpf_pkg::BANK_AW-1:0] p2_row_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (adv) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_write    <= p1_write;
      p2_waddr    <= p1_waddr;
      p2_wdata    <= p1_wdata;
      p2_col      <= p1_col;
      p2_fine_x   <= p1_fine_x;
      p2_row_addr <= row_addr;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: read both bit planes; writes reach the banks here, in order
  // ---------------------------------------------------------------------------
  logic       p2_wr_live;
  logic [7:0] p3_lo;
  logic [7:0] p3_hi;

  assign p2_wr_live = adv && p2_valid && p2_write;

  tbpf_ram #(
    .WIDTH (8),
    .DEPTH (1 << tbpf_pkg::BANK_AW)
  ) u_lo_bank (
    .clk   (clk),
    .we    (p2_wr_live && !p2_waddr[0]),
    .waddr (p2_waddr[tbpf_pkg::VRAM_AW-1:1]),
    .wdata (p2_wdata),
    .re    (adv),
    .raddr (p2_row_addr),
    .rdata (p3_lo)
  );

  tbpf_ram #(
    .WIDTH (8),
    .DEPTH (1 << tbpf_pkg::BANK_AW)
  ) u_hi_bank (
    .clk   (clk),
    .we    (p2_wr_live && p2_waddr[0]),
    .waddr (p2_waddr[tbpf_pkg::VRAM_AW-1:1]),
    .wdata (p2_wdata),
    .re    (adv),
    .raddr (p2_row_addr),
    .rdata (p3_hi)
  );

  // stage 3 carries renders only; writes end at the banks
  logic       p3_valid;
  logic [7:0] p3_col;
  logic [2:0] p3_fine_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (adv) begin
      p3_valid <= p2_valid && !p2_write;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_col    <= p2_col;
      p3_fine_x <= p2_fine_x;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: pick the pixel bit (msb is leftmost) and apply the palette
  // ---------------------------------------------------------------------------
  logic [2:0]     bit_sel;
  logic [1:0]     pix_idx;
  tbpf_pkg::res_t pix_word;
  logic           res_fire;

  assign bit_sel  = ~p3_fine_x;  // 7 - fine x
  assign pix_idx  = {p3_hi[bit_sel], p3_lo[bit_sel]};
  assign pix_word = '{out_col:     p3_col,
                      color_index: pix_idx,
                      pixel_shade: bg_palette[{pix_idx, 1'b0} +: 2]};
  assign res_fire = adv && p3_valid;

  // output register plus one skid word, so input stays open while a result waits
  logic           out_valid;
  tbpf_pkg::res_t out_word;
  tbpf_pkg::res_t skid_word;
  logic           out_free;

  assign out_free  = !out_valid || res.ready;
  assign res.valid = out_valid;
  assign res.data  = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word <= skid_valid ? skid_word : pix_word;
    end else if (res_fire) begin
      skid_word <= pix_word;
    end
  end

`ifndef SYNTH
  // skid word only exists behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  // skid fills or stays only while the output was stalled
  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> $past(out_valid && !res.ready))
    else $error("skid word without an output stall");

  // a new result comes straight from the last pipeline stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(p3_valid))
    else $error("result appeared without a finished render");

  // off-screen columns never produce a result
  a_col_on_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_word.out_col} < COL_LIMIT))
    else $error("result for a column off the screen");
`endif

endmodule

@@ verif/tb.sv @@
// tb: self-checking bench for tile_background_pixel_fetch_top, with random stimulus and a
// cycle-free pixel predictor; depends on tbpf_pkg, tbpf_stream_if and the rtl top level
module tb;

  localparam int SCREEN_COLS  = 160;
  localparam int VRAM_BYTES   = 8192;
  localparam int MAP_LOW      = 'h1800;  // 0x9800 as an offset from 0x8000
  localparam int MAP_HIGH     = 'h1C00;  // 0x9c00
  localparam int SIGNED_BASE  = 'h1000;  // 0x9000
  localparam int MAP_COLS     = 32;
  localparam int DRAIN_CYCLES = 8;       // lets the pipeline empty, with slack to spare
  localparam int IDLE_LIMIT   = 2000;    // longest legal quiet stretch is well under this
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_WORDS  = 205;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tbpf_stream_if #(.payload_t(tbpf_pkg::cfg_t)) cfg_ch ();
  tbpf_stream_if #(.payload_t(tbpf_pkg::req_t)) req_ch ();
  tbpf_stream_if #(.payload_t(tbpf_pkg::res_t)) res_ch ();

  tile_background_pixel_fetch_top #(
    .SCREEN_COLS(SCREEN_COLS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .req(req_ch),
    .res(res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the block: video memory and registers as of accepted words
  logic [7:0] vid_mem [0:VRAM_BYTES-1];
  logic [7:0] lcdc_reg, scy_reg, scx_reg, pal_reg;

  // stimulus-side copy: what memory will hold once everything queued has gone in,
  // plus which bytes were ever written, so no render touches an undefined byte
  logic [7:0] stage_mem [0:VRAM_BYTES-1];
  bit         stage_set [0:VRAM_BYTES-1];
  logic [7:0] plan_lcdc, plan_scy, plan_scx;

  tbpf_pkg::req_t pending_words [$];
  tbpf_pkg::res_t pixel_expect [$];

  int  queued_words   = 0;
  int  accepted_words = 0;
  int  pixels_due     = 0;
  int  results_seen   = 0;
  int  mismatch_count = 0;
  int  idle_cycles    = 0;
  int  gap_left       = 0;
  int  hold_left      = 0;
  bit  long_stall_done = 1'b0;
  bit  calm           = 1'b0;  // no idling on either side

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // tile map byte for a scrolled pixel position; map column wraps within 32 tiles
  function automatic int map_entry_ofs(input logic [7:0] lcdc, input int y, input int x);
    return (lcdc[tbpf_pkg::LCDC_MAP_SEL] ? MAP_HIGH : MAP_LOW) + (y / 8) * MAP_COLS + (x / 8);
  endfunction

  // low bit-plane byte of the tile row, signed or unsigned tile numbering
  function automatic int tile_row_ofs(input logic [7:0] lcdc, input logic [7:0] tile,
                                      input int y);
    int base;
    if (lcdc[tbpf_pkg::LCDC_DATA_SEL]) begin
      base = int'(tile) * 16;
    end else begin
      base = SIGNED_BASE + (tile[7] ? (int'(tile) - 256) * 16 : int'(tile) * 16);
    end
    return (base + (y % 8) * 2) & (VRAM_BYTES - 1);
  endfunction

  // expected pixel for a render word; returns 0 when the column is off screen
  function automatic bit fetch_pixel(input tbpf_pkg::req_t w, output tbpf_pkg::res_t px);
    int         y, x, ofs, bitpos;
    logic [7:0] tile, lo, hi;
    logic [1:0] idx;
    px = '0;
    if (int'(w.pixel_col) >= SCREEN_COLS) return 1'b0;
    y = (int'(scy_reg) + int'(w.screen_line)) & 255;
    x = (int'(scx_reg) + int'(w.pixel_col)) & 255;
    tile = vid_mem[map_entry_ofs(lcdc_reg, y, x)];
    ofs = tile_row_ofs(lcdc_reg, tile, y);
    lo = vid_mem[ofs];
    hi = vid_mem[(ofs + 1) & (VRAM_BYTES - 1)];
    bitpos = 7 - (x & 7);
    idx = {hi[bitpos], lo[bitpos]};
    px.out_col = w.pixel_col;
    px.color_index = idx;
    px.pixel_shade = pal_reg[2 * idx +: 2];
    return 1'b1;
  endfunction

  task automatic queue_write(input logic [12:0] addr, input logic [7:0] data);
    tbpf_pkg::req_t w;
    w.req_type    = tbpf_pkg::REQ_WRITE;
    w.vram_addr   = addr;
    w.write_data  = data;
    w.pixel_col   = 8'($urandom);   // unused on a write, keep the bits moving
    w.screen_line = 8'($urandom);
    pending_words.push_back(w);
    queued_words++;
    stage_mem[addr] = data;
    stage_set[addr] = 1'b1;
  endtask

  // a render word, preceded by writes to any map or tile byte it needs that
  // has never been written
  task automatic queue_render(input int col, input int line);
    tbpf_pkg::req_t w;
    int             y, x, map_ofs, ofs;
    logic [7:0]     tile;
    if (col < SCREEN_COLS) begin
      y = (int'(plan_scy) + line) & 255;
      x = (int'(plan_scx) + col) & 255;
      map_ofs = map_entry_ofs(plan_lcdc, y, x);
      if (!stage_set[map_ofs]) queue_write(13'(map_ofs), 8'($urandom));
      tile = stage_mem[map_ofs];
      ofs = tile_row_ofs(plan_lcdc, tile, y);
      if (!stage_set[ofs]) queue_write(13'(ofs), 8'($urandom));
      if (!stage_set[ofs + 1]) queue_write(13'(ofs + 1), 8'($urandom));
    end
    w.req_type    = tbpf_pkg::REQ_RENDER;
    w.vram_addr   = 13'($urandom);
    w.write_data  = 8'($urandom);
    w.pixel_col   = 8'(col);
    w.screen_line = 8'(line);
    pending_words.push_back(w);
    queued_words++;
  endtask

  // wait until every queued word is in and every predicted pixel is back,
  // then let the pipeline empty of words that give no pixel
  task automatic drain();
    wait (accepted_words == queued_words && pixels_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all four registers back to back; called only with the block idle
  task automatic set_regs(input logic [7:0] lcdc, input logic [7:0] scy,
                          input logic [7:0] scx, input logic [7:0] pal);
    logic [7:0] vals [4];
    logic [7:0] idxs [4];
    vals = '{lcdc, scy, scx, pal};
    idxs = '{tbpf_pkg::CFG_LCD_CONTROL, tbpf_pkg::CFG_SCROLL_Y,
             tbpf_pkg::CFG_SCROLL_X, tbpf_pkg::CFG_BG_PALETTE};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= {idxs[i], vals[i]};
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    plan_lcdc = lcdc;
    plan_scy  = scy;
    plan_scx  = scx;
  endtask

  // sender: one word offered at a time, held until taken, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left = 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (gap_left > 0) begin
        req_ch.valid <= 1'b0;
        gap_left--;
      end else if (pending_words.size() > 0) begin
        req_ch.valid <= 1'b1;
        req_ch.data  <= pending_words.pop_front();
        if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 5);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: short random stalls, and once a long hold-off so the pipe
  // backs up and the request side has to stall
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left--;
    end else if (!long_stall_done && results_seen >= 150 && pending_words.size() > 20) begin
      long_stall_done = 1'b1;
      hold_left = 80;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 4);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // predictor: follows accepted config and request words
  always @(posedge clk) begin
    tbpf_pkg::res_t px;
    if (rst) begin
      lcdc_reg = '0;
      scy_reg  = '0;
      scx_reg  = '0;
      pal_reg  = '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          tbpf_pkg::CFG_LCD_CONTROL: lcdc_reg = cfg_ch.data.value;
          tbpf_pkg::CFG_SCROLL_Y:    scy_reg  = cfg_ch.data.value;
          tbpf_pkg::CFG_SCROLL_X:    scx_reg  = cfg_ch.data.value;
          tbpf_pkg::CFG_BG_PALETTE:  pal_reg  = cfg_ch.data.value;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        accepted_words++;
        if (req_ch.data.req_type == tbpf_pkg::REQ_WRITE) begin
          vid_mem[req_ch.data.vram_addr] = req_ch.data.write_data;
        end else if (fetch_pixel(req_ch.data, px)) begin
          pixel_expect.push_back(px);
          pixels_due++;
        end
      end
    end
  end

  // checker: each pixel taken against the oldest prediction
  always @(posedge clk) begin
    tbpf_pkg::res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (pixel_expect.size() == 0) begin
        report($sformatf("pixel for column %0d with none pending", res_ch.data.out_col));
      end else begin
        want = pixel_expect.pop_front();
        pixels_due--;
        if (res_ch.data.out_col !== want.out_col)
          report($sformatf("out_col got %0d expected %0d",
                           res_ch.data.out_col, want.out_col));
        if (res_ch.data.color_index !== want.color_index)
          report($sformatf("color_index col %0d got %0d expected %0d",
                           want.out_col, res_ch.data.color_index, want.color_index));
        if (res_ch.data.pixel_shade !== want.pixel_shade)
          report($sformatf("pixel_shade col %0d got %0d expected %0d",
                           want.out_col, res_ch.data.pixel_shade, want.pixel_shade));
      end
    end
  end

  // watchdog: too long without any word moving on any channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int pick, col, line;
    int phase_start;
    bit held;
    // known values on every input before the first edge
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    res_ch.ready = 1'b0;
    plan_lcdc = '0;
    plan_scy  = '0;
    plan_scx  = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: 0x9800 map, signed tile numbers, no scroll
    set_regs(8'h00, 8'h00, 8'h00, 8'hE4);
    // tile number 0x80 in signed mode lands below 0x9000, at 0x8800
    queue_write(13'h1800, 8'h80);
    queue_write(13'h0800, 8'hA5);
    queue_write(13'h0801, 8'h3C);
    queue_render(0, 0);      // leftmost bit of the row
    queue_render(7, 0);      // rightmost bit of the row
    // address and data extremes
    queue_write(13'h1FFF, 8'hFF);
    queue_write(13'h0000, 8'h00);
    queue_render(159, 0);    // last visible column
    queue_render(160, 0);    // first column off screen, no pixel
    queue_render(255, 143);  // far off screen
    queue_render(80, 143);   // last visible line
    queue_render(0, 255);    // line past the screen is used as given
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = (p == NUM_PHASES - 1);
      case (p)
        0: set_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);  // 0x9c00 map, unsigned, full wrap
        1: set_regs(8'h08, 8'd7, 8'd250, 8'h1B);  // 0x9c00 map, signed
        2: set_regs(8'h10, 8'd200, 8'd13, 8'h00); // 0x9800 map, unsigned
        3: set_regs(8'hE7, 8'($urandom), 8'($urandom), 8'($urandom));
        default: set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      // fill writes count toward the phase budget
      phase_start = queued_words;
      held = 1'b0;
      while (queued_words - phase_start < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          // stray write anywhere, may retarget a map entry or a tile row
          queue_write(13'($urandom), 8'($urandom));
        end else if (pick < 20) begin
          queue_render($urandom_range(SCREEN_COLS, 255), $urandom_range(0, 255));
        end else begin
          col  = (pick < 24) ? ((pick & 1) ? SCREEN_COLS - 1 : 0)
                             : $urandom_range(0, SCREEN_COLS - 1);
          line = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 143)
                                              : $urandom_range(144, 255);
          queue_render(col, line);
        end
        // sender holds back mid-phase until every pixel has come back
        if (p == 3 && !held && queued_words - phase_start >= PHASE_WORDS / 2) begin
          held = 1'b1;
          drain();
        end
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tbpf_pkg.sv
rtl/tbpf_stream_if.sv
rtl/tbpf_ram.sv
rtl/tile_background_pixel_fetch_top.sv
verif/tb.sv
